### design/pc_pkg.sv
// Package for the path canonicalizer: operation and status codes, character
// constants and the structs passed between the top level and the path walker.
// No dependencies.
package pc_pkg;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2
    } pc_op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_ABS    = 3'd1,
        ST_BAD_CHAR   = 3'd2,
        ST_ABOVE_ROOT = 3'd3,
        ST_DOT_STRICT = 3'd4,
        ST_TOO_LONG   = 3'd5
    } pc_status_t;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    typedef struct packed {
        logic       too_long;
        logic       not_abs;
        logic       bad_char;
    } pc_err_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] index;
    } pc_item_t;

    typedef struct packed {
        pc_status_t status;
        logic [7:0] count;
        logic [8:0] length;
        logic       read_ok;
    } pc_result_t;

endpackage

### design/pc_store.sv
// Canonical path store, split into an even and an odd byte bank so that a
// separator and a path byte can be written in the same cycle.
// Depends on nothing but its parameter.
module pc_store #(
    parameter int STORE_BYTES = 256
) (
    input  logic                               clk,
    input  logic                               wr_en0,
    input  logic [$clog2(STORE_BYTES+1)-1:0]   wr_pos0,
    input  logic [7:0]                         wr_data0,
    input  logic                               wr_en1,
    input  logic [$clog2(STORE_BYTES+1)-1:0]   wr_pos1,
    input  logic [7:0]                         wr_data1,
    input  logic                               rd_en,
    input  logic [$clog2(STORE_BYTES+1)-1:0]   rd_pos,
    input  logic                               rd_ok,
    output logic [7:0]                         read_byte
);

    localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
    localparam int BA = $clog2(BANK_DEPTH);

    logic [7:0]    even_mem [BANK_DEPTH];
    logic [7:0]    odd_mem  [BANK_DEPTH];
    logic          even_we;
    logic [BA-1:0] even_wa;
    logic [7:0]    even_wd;
    logic          odd_we;
    logic [BA-1:0] odd_wa;
    logic [7:0]    odd_wd;
    logic [7:0]    even_q_reg;
    logic [7:0]    odd_q_reg;
    logic          sel_reg;
    logic          ok_reg;

    always_comb
    begin
        even_we = 1'b0;
        even_wa = wr_pos0[BA:1];
        even_wd = wr_data0;
        odd_we  = 1'b0;
        odd_wa  = wr_pos0[BA:1];
        odd_wd  = wr_data0;
        if (wr_en0)
        begin
            if (wr_pos0[0])
            begin
                odd_we = 1'b1;
            end
            else
            begin
                even_we = 1'b1;
            end
        end
        if (wr_en1)
        begin
            if (wr_pos1[0])
            begin
                odd_we = 1'b1;
                odd_wa = wr_pos1[BA:1];
                odd_wd = wr_data1;
            end
            else
            begin
                even_we = 1'b1;
                even_wa = wr_pos1[BA:1];
                even_wd = wr_data1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[even_wa] <= even_wd;
        end
        if (odd_we)
        begin
            odd_mem[odd_wa] <= odd_wd;
        end
        if (rd_en)
        begin
            even_q_reg <= even_mem[rd_pos[BA:1]];
            odd_q_reg  <= odd_mem[rd_pos[BA:1]];
            sel_reg    <= rd_pos[0];
            ok_reg     <= rd_ok;
        end
    end

    assign read_byte = !ok_reg ? 8'd0 : (sel_reg ? odd_q_reg : even_q_reg);

endmodule

### design/pc_walk.sv
// Path walker: per-path counters, component tracking, separator position
// stack and status, updated once per beat from the input register.
// Depends on pc_pkg.
module pc_walk
    import pc_pkg::*;
#(
    parameter int MAX_PATH_LEN   = 255,
    parameter int MAX_COMPONENTS = 128,
    parameter int STORE_BYTES    = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               strict,
    input  logic                               item_fire,
    input  pc_item_t                           item,
    output pc_result_t                         res,
    output logic                               wr_en0,
    output logic [$clog2(STORE_BYTES+1)-1:0]   wr_pos0,
    output logic [7:0]                         wr_data0,
    output logic                               wr_en1,
    output logic [$clog2(STORE_BYTES+1)-1:0]   wr_pos1,
    output logic [7:0]                         wr_data1
);

    localparam int LW = $clog2(STORE_BYTES + 1);
    localparam int DW = $clog2(MAX_COMPONENTS + 1);
    localparam int SA = $clog2(MAX_COMPONENTS);
    localparam int BW = $clog2(MAX_PATH_LEN + 2);

    logic [LW-1:0] slash_mem [MAX_COMPONENTS];

    logic [LW-1:0] olen_reg, olen_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [BW-1:0] bcount_reg, bcount_next;
    logic          inside_reg, inside_next;
    logic [1:0]    cchars_reg, cchars_next;
    logic [1:0]    dotpat_reg, dotpat_next;
    pc_err_t       err_reg, err_next;
    pc_status_t    fwe_reg, fwe_next;
    logic          finished_reg, finished_next;
    logic [LW-1:0] top1_reg, top1_next;
    logic [LW-1:0] top2_reg, top2_next;
    logic          pend_reg, pend_next;
    logic [LW-1:0] rd1_reg;
    logic [LW-1:0] rd2_reg;

    logic [LW-1:0] top1_eff;
    logic [LW-1:0] top2_eff;
    logic          sp_we;
    logic [SA-1:0] sp_wa;
    logic [LW-1:0] sp_wd;
    logic [SA-1:0] ra1;
    logic [SA-1:0] ra2;
    logic          start;
    logic          do_close;
    logic          char_ok;
    logic [1:0]    drop;
    logic [DW-1:0] d_new;
    pc_status_t    st;

    always_comb
    begin
        top1_eff      = pend_reg ? rd1_reg : top1_reg;
        top2_eff      = pend_reg ? rd2_reg : top2_reg;
        olen_next     = olen_reg;
        depth_next    = depth_reg;
        bcount_next   = bcount_reg;
        inside_next   = inside_reg;
        cchars_next   = cchars_reg;
        dotpat_next   = dotpat_reg;
        err_next      = err_reg;
        fwe_next      = fwe_reg;
        finished_next = finished_reg;
        top1_next     = top1_eff;
        top2_next     = top2_eff;
        pend_next     = 1'b0;
        sp_we         = 1'b0;
        sp_wa         = SA'(depth_reg);
        sp_wd         = olen_reg;
        ra1           = '0;
        ra2           = '0;
        wr_en0        = 1'b0;
        wr_pos0       = olen_reg;
        wr_data0      = CHAR_SLASH;
        wr_en1        = 1'b0;
        wr_pos1       = olen_reg;
        wr_data1      = item.data;
        do_close      = 1'b0;
        char_ok       = 1'b1;
        drop          = 2'd0;
        d_new         = depth_reg;
        st            = ST_OK;
        res.status    = ST_OK;
        res.count     = 8'(depth_reg);
        res.length    = 9'(olen_reg);
        res.read_ok   = 1'b0;

        start = finished_reg && item_fire &&
                (item.op == OP_BYTE || item.op == OP_END);
        if (start)
        begin
            olen_next     = '0;
            depth_next    = '0;
            bcount_next   = '0;
            inside_next   = 1'b0;
            cchars_next   = 2'd0;
            dotpat_next   = 2'd0;
            err_next      = '0;
            fwe_next      = ST_OK;
            finished_next = 1'b0;
            if (strict && (item.op == OP_END || item.data != CHAR_SLASH))
            begin
                err_next.not_abs = 1'b1;
            end
        end

        if (item_fire)
        begin
            case (pc_op_t'(item.op))
                OP_BYTE:
                begin
                    if (bcount_next <= BW'(MAX_PATH_LEN))
                    begin
                        bcount_next = bcount_next + BW'(1);
                    end
                    if (bcount_next > BW'(MAX_PATH_LEN))
                    begin
                        err_next.too_long = 1'b1;
                    end
                    if (item.data < CHAR_SPACE)
                    begin
                        err_next.bad_char = 1'b1;
                    end
                    if (err_next == '0 && fwe_next == ST_OK)
                    begin
                        if (item.data == CHAR_SLASH)
                        begin
                            do_close = inside_next;
                        end
                        else
                        begin
                            if (!inside_next)
                            begin
                                if (depth_next >= DW'(MAX_COMPONENTS))
                                begin
                                    err_next.too_long = 1'b1;
                                    char_ok = 1'b0;
                                end
                                else
                                begin
                                    sp_we       = 1'b1;
                                    sp_wa       = SA'(depth_next);
                                    sp_wd       = olen_next;
                                    top2_next   = top1_eff;
                                    top1_next   = olen_next;
                                    depth_next  = depth_next + DW'(1);
                                    if (olen_next >= LW'(STORE_BYTES))
                                    begin
                                        err_next.too_long = 1'b1;
                                    end
                                    else
                                    begin
                                        wr_en0    = 1'b1;
                                        wr_pos0   = olen_next;
                                        olen_next = olen_next + LW'(1);
                                    end
                                    inside_next = 1'b1;
                                    cchars_next = 2'd0;
                                    dotpat_next = 2'd0;
                                end
                            end
                            if (char_ok)
                            begin
                                if (item.data == CHAR_DOT && cchars_next < 2'd2)
                                begin
                                    dotpat_next[cchars_next[0]] = 1'b1;
                                end
                                if (cchars_next < 2'd3)
                                begin
                                    cchars_next = cchars_next + 2'd1;
                                end
                                if (olen_next >= LW'(STORE_BYTES))
                                begin
                                    err_next.too_long = 1'b1;
                                end
                                else
                                begin
                                    wr_en1    = 1'b1;
                                    wr_pos1   = olen_next;
                                    olen_next = olen_next + LW'(1);
                                end
                            end
                        end
                    end
                end
                OP_END:
                begin
                    do_close = (err_next == '0) && (fwe_next == ST_OK) && inside_next;
                end
                OP_READ:
                begin
                    res.read_ok = item.index < olen_reg;
                end
                default:
                begin
                end
            endcase
        end

        if (do_close)
        begin
            inside_next = 1'b0;
            if (cchars_next == 2'd1 && dotpat_next[0])
            begin
                drop = 2'd1;
            end
            else if (cchars_next == 2'd2 && dotpat_next == 2'd3)
            begin
                drop = 2'd2;
            end
            if (drop != 2'd0)
            begin
                if (depth_next < DW'(drop))
                begin
                    fwe_next = ST_ABOVE_ROOT;
                end
                else
                begin
                    d_new      = depth_next - DW'(drop);
                    ra1        = SA'(d_new - DW'(1));
                    ra2        = SA'(d_new - DW'(2));
                    olen_next  = (drop == 2'd1) ? top1_eff : top2_eff;
                    depth_next = d_new;
                    pend_next  = 1'b1;
                    if (strict)
                    begin
                        fwe_next = ST_DOT_STRICT;
                    end
                end
            end
        end

        if (item_fire && item.op == OP_END)
        begin
            inside_next = 1'b0;
            if (err_next.too_long)
            begin
                st = ST_TOO_LONG;
            end
            else if (err_next.not_abs)
            begin
                st = ST_NOT_ABS;
            end
            else if (err_next.bad_char)
            begin
                st = ST_BAD_CHAR;
            end
            else
            begin
                st = fwe_next;
            end
            if (st != ST_OK)
            begin
                olen_next  = '0;
                depth_next = '0;
            end
            finished_next = 1'b1;
            res.status    = st;
            res.count     = 8'(depth_next);
            res.length    = 9'(olen_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            olen_reg     <= '0;
            depth_reg    <= '0;
            bcount_reg   <= '0;
            inside_reg   <= 1'b0;
            cchars_reg   <= 2'd0;
            dotpat_reg   <= 2'd0;
            err_reg      <= '0;
            fwe_reg      <= ST_OK;
            finished_reg <= 1'b1;
            pend_reg     <= 1'b0;
        end
        else
        begin
            olen_reg     <= olen_next;
            depth_reg    <= depth_next;
            bcount_reg   <= bcount_next;
            inside_reg   <= inside_next;
            cchars_reg   <= cchars_next;
            dotpat_reg   <= dotpat_next;
            err_reg      <= err_next;
            fwe_reg      <= fwe_next;
            finished_reg <= finished_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top1_reg <= top1_next;
        top2_reg <= top2_next;
        if (sp_we)
        begin
            slash_mem[sp_wa] <= sp_wd;
        end
        rd1_reg <= slash_mem[ra1];
        rd2_reg <= slash_mem[ra2];
    end

endmodule

### design/path_canonicalizer.sv
// Top level of the path canonicalizer: input register, result register and
// handshakes around the path walker and the canonical store.
// Depends on pc_pkg, pc_walk and pc_store.
//
//  Channel  Signals                                          Direction
//  in       in_valid/in_ready, operation, path_byte, read_index   into block
//  out      out_valid/out_ready, status, component_count,
//           canonical_length, read_byte                      out of block
//  cfg      cfg_valid/cfg_ready, cfg_data (strict mode)      into block
//
// One beat is accepted per cycle unless a held result blocks the input register; end
// and read beats show their result after the walk between the input and result registers.
// Reset clears all control state; the stores need no clearing pass.
// A stalled result holds the result register; the input register still
// accepts one more beat, and path bytes keep flowing since they give no result.
module path_canonicalizer
    import pc_pkg::*;
#(
    parameter int MAX_PATH_LEN   = 255,
    parameter int MAX_COMPONENTS = 128,
    parameter int STORE_BYTES    = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] path_byte,
    input  logic [7:0] read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] component_count,
    output logic [8:0] canonical_length,
    output logic [7:0] read_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int LW = $clog2(STORE_BYTES + 1);

    logic          s1_valid_reg, s1_valid_next;
    pc_item_t      s1_item_reg;
    logic          out_valid_reg, out_valid_next;
    pc_result_t    out_res_reg;
    logic          strict_reg;
    logic          s1_has_result;
    logic          out_free;
    logic          s1_advance;
    logic          res_load;
    pc_result_t    res;
    logic          wr_en0;
    logic [LW-1:0] wr_pos0;
    logic [7:0]    wr_data0;
    logic          wr_en1;
    logic [LW-1:0] wr_pos1;
    logic [7:0]    wr_data1;

    assign s1_has_result = s1_item_reg.op == OP_END || s1_item_reg.op == OP_READ;
    assign out_free      = !out_valid_reg || out_ready;
    assign s1_advance    = s1_valid_reg && (!s1_has_result || out_free);
    assign res_load      = s1_advance && s1_has_result;
    assign in_ready      = !s1_valid_reg || s1_advance;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            strict_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                strict_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= '{op: operation, data: path_byte, index: read_index};
        end
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    pc_walk #(
        .MAX_PATH_LEN   (MAX_PATH_LEN),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .STORE_BYTES    (STORE_BYTES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .strict    (strict_reg),
        .item_fire (s1_advance),
        .item      (s1_item_reg),
        .res       (res),
        .wr_en0    (wr_en0),
        .wr_pos0   (wr_pos0),
        .wr_data0  (wr_data0),
        .wr_en1    (wr_en1),
        .wr_pos1   (wr_pos1),
        .wr_data1  (wr_data1)
    );

    pc_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .clk       (clk),
        .wr_en0    (wr_en0),
        .wr_pos0   (wr_pos0),
        .wr_data0  (wr_data0),
        .wr_en1    (wr_en1),
        .wr_pos1   (wr_pos1),
        .wr_data1  (wr_data1),
        .rd_en     (res_load),
        .rd_pos    (LW'(s1_item_reg.index)),
        .rd_ok     (res.read_ok),
        .read_byte (read_byte)
    );

    assign out_valid        = out_valid_reg;
    assign status           = out_res_reg.status;
    assign component_count  = out_res_reg.count;
    assign canonical_length = out_res_reg.length;

`ifndef SYNTHESIS
    a_error_clears_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> canonical_length == 9'd0 && component_count == 8'd0)
        else $error("error result carries a nonzero length or count");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_has_result && out_valid_reg)
        else $error("input stalled without a pending result");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the input register");

    a_error_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_byte == 8'd0)
        else $error("error result carries a read byte");
`endif

endmodule

### bench/path_canonicalizer_checker.sv
// Checker for the path canonicalizer: watches the config, input and result channels,
// keeps its own model of the canonical path and compares every result beat field by field.
// Depends on pc_pkg.
module path_canonicalizer_checker
    import pc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] path_byte,
    input  logic [7:0] read_index,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] status,
    input  logic [7:0] component_count,
    input  logic [8:0] canonical_length,
    input  logic [7:0] read_byte,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         mismatches,
    output int         pending,
    output int         results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PATH_LIMIT = 255;
    localparam int COMP_LIMIT = 128;
    localparam int STORE_SIZE = 256;

    typedef struct packed {
        pc_status_t status;
        logic [7:0] count;
        logic [8:0] length;
        logic [7:0] data;
    } canon_result_t;

    canon_result_t canon_results_q[$];

    logic       strict_mode;
    logic [7:0] canon_mem [STORE_SIZE];
    logic [8:0] slash_at [COMP_LIMIT];
    logic [8:0] canon_len;
    logic [7:0] depth;
    logic [8:0] bytes_in;
    logic       in_comp;
    logic [1:0] comp_chars;
    logic [1:0] dots;
    pc_err_t    errs;
    pc_status_t walk_err;
    logic       path_done;

    function automatic void begin_path();
        canon_len  = 9'd0;
        depth      = 8'd0;
        bytes_in   = 9'd0;
        in_comp    = 1'b0;
        comp_chars = 2'd0;
        dots       = 2'b00;
        errs       = '0;
        walk_err   = ST_OK;
        path_done  = 1'b0;
    endfunction

    function automatic logic walk_failed();
        return (errs != '0) || (walk_err != ST_OK);
    endfunction

    function automatic void append(input logic [7:0] b);
        if (canon_len >= STORE_SIZE)
        begin
            errs.too_long = 1'b1;
            return;
        end
        canon_mem[canon_len[7:0]] = b;
        canon_len++;
    endfunction

    // A single dot drops itself; a double dot also pops the component before it.
    function automatic void close_comp();
        logic [1:0] drop;
        in_comp = 1'b0;
        drop = 2'd0;
        if (comp_chars == 2'd1 && dots[0])
            drop = 2'd1;
        else if (comp_chars == 2'd2 && dots == 2'b11)
            drop = 2'd2;
        if (drop == 2'd0)
            return;
        if (depth < drop)
        begin
            walk_err = ST_ABOVE_ROOT;
            return;
        end
        depth = depth - drop;
        canon_len = slash_at[depth[6:0]];
        if (strict_mode)
            walk_err = ST_DOT_STRICT;
    endfunction

    function automatic void take_path_byte(input logic [7:0] b);
        if (path_done)
        begin
            begin_path();
            if (strict_mode && b != CHAR_SLASH)
                errs.not_abs = 1'b1;
        end
        if (bytes_in <= PATH_LIMIT)
            bytes_in++;
        if (bytes_in > PATH_LIMIT)
            errs.too_long = 1'b1;
        if (b < CHAR_SPACE)
            errs.bad_char = 1'b1;
        if (walk_failed())
            return;
        if (b == CHAR_SLASH)
        begin
            if (in_comp)
                close_comp();
            return;
        end
        if (!in_comp)
        begin
            if (depth >= COMP_LIMIT)
            begin
                errs.too_long = 1'b1;
                return;
            end
            slash_at[depth[6:0]] = canon_len;
            depth++;
            append(CHAR_SLASH);
            in_comp    = 1'b1;
            comp_chars = 2'd0;
            dots       = 2'b00;
        end
        if (b == CHAR_DOT && comp_chars < 2'd2)
            dots[comp_chars[0]] = 1'b1;
        if (comp_chars < 2'd3)
            comp_chars++;
        append(b);
    endfunction

    function automatic canon_result_t finish_path();
        canon_result_t res;
        if (path_done)
        begin
            begin_path();
            if (strict_mode)
                errs.not_abs = 1'b1;
        end
        if (!walk_failed() && in_comp)
            close_comp();
        in_comp = 1'b0;
        if (errs.too_long)
            res.status = ST_TOO_LONG;
        else if (errs.not_abs)
            res.status = ST_NOT_ABS;
        else if (errs.bad_char)
            res.status = ST_BAD_CHAR;
        else
            res.status = walk_err;
        if (res.status != ST_OK)
        begin
            canon_len = 9'd0;
            depth     = 8'd0;
        end
        path_done  = 1'b1;
        res.count  = depth;
        res.length = canon_len;
        res.data   = 8'h00;
        return res;
    endfunction

    function automatic canon_result_t read_canon(input logic [7:0] index);
        canon_result_t res;
        res.status = ST_OK;
        res.count  = depth;
        res.length = canon_len;
        res.data   = (index < canon_len) ? canon_mem[index] : 8'h00;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        canon_result_t want;
        if (!rst_n)
        begin
            canon_results_q.delete();
            mismatches   = 0;
            results_seen = 0;
            strict_mode  = 1'b0;
            foreach (canon_mem[i])
                canon_mem[i] = 8'h00;
            foreach (slash_at[i])
                slash_at[i] = 9'd0;
            begin_path();
            path_done = 1'b1;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (canon_results_q.size() == 0)
                begin
                    $error("result beat arrived with no prediction pending");
                    mismatches++;
                end
                else
                begin
                    want = canon_results_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (component_count !== want.count)
                    begin
                        $error("component_count: expected %0d, got %0d",
                               want.count, component_count);
                        mismatches++;
                    end
                    if (canonical_length !== want.length)
                    begin
                        $error("canonical_length: expected %0d, got %0d",
                               want.length, canonical_length);
                        mismatches++;
                    end
                    if (read_byte !== want.data)
                    begin
                        $error("read_byte: expected %0h, got %0h", want.data, read_byte);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                strict_mode = cfg_data;
            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_BYTE: take_path_byte(path_byte);
                    OP_END:  canon_results_q.push_back(finish_path());
                    OP_READ: canon_results_q.push_back(read_canon(read_index));
                    default: ;
                endcase
            end
        end
        pending = canon_results_q.size();
    end

endmodule

### bench/path_canonicalizer_test.sv
// Top of the path canonicalizer testbench: clock, reset, path stimulus, output stalls
// and the verdict. Depends on pc_pkg, path_canonicalizer and path_canonicalizer_checker.
module path_canonicalizer_test
    import pc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_IGNORED  = 2'd3;
    localparam int         DRAIN_CYCLES = 6;
    localparam int         LONG_STALL   = 400;
    localparam int         CYCLE_LIMIT  = 200000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] operation;
    logic [7:0] path_byte;
    logic [7:0] read_index;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic [7:0] component_count;
    logic [8:0] canonical_length;
    logic [7:0] read_byte;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    int mismatches;
    int pending;
    int results_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent    = 0;
    int paths_sent    = 0;
    int stall_asks    = 0;
    int stalls_done   = 0;
    int stall_left    = 0;
    int cycle_count   = 0;

    logic [7:0] path_q[$];

    path_canonicalizer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .path_byte        (path_byte),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .component_count  (component_count),
        .canonical_length (canonical_length),
        .read_byte        (read_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    path_canonicalizer_checker i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .path_byte        (path_byte),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .component_count  (component_count),
        .canonical_length (canonical_length),
        .read_byte        (read_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_seen     (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("path_canonicalizer verification failed");
            $finish;
        end
    end

    // Output side: random back-pressure, plus a long hold-off whenever one is asked for.
    always @(negedge clk)
    begin
        if (stalls_done != stall_asks)
        begin
            stall_left  = LONG_STALL;
            stalls_done = stall_asks;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] data,
                             input logic [7:0] index);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        path_byte  <= data;
        read_index <= index;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (op != OP_IGNORED)
            beats_sent++;
    endtask

    task automatic send_path(input int n_reads);
        foreach (path_q[i])
        begin
            if ($urandom_range(15) == 0)
                send_beat(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(15)));
            send_beat(OP_BYTE, path_q[i], 8'($urandom_range(255)));
        end
        send_beat(OP_END, 8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat (n_reads)
            send_beat(OP_READ, 8'($urandom_range(255)),
                      8'($urandom_range(1) ? $urandom_range(20) : $urandom_range(255)));
        paths_sent++;
    endtask

    task automatic queue_text(input string s);
        path_q.delete();
        for (int i = 0; i < s.len(); i++)
            path_q.push_back(s[i]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_strict(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(199) == 0)
            return 8'($urandom_range(31));
        if ($urandom_range(9) == 0)
            return CHAR_DOT;
        c = 8'($urandom_range(8'h21, 8'hFF));
        return (c == CHAR_SLASH) ? CHAR_DOT : c;
    endfunction

    // Mostly well-formed paths with random components, some long ones and some raw noise.
    task automatic run_phase(input int n_beats);
        int stop_at;
        int kind;
        int n_comp;
        int n_len;
        int r;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at)
        begin
            path_q.delete();
            kind = $urandom_range(99);
            if (kind < 3)
            begin
                n_len = $urandom_range(240, 270);
                if ($urandom_range(1) == 1)
                    path_q.push_back(CHAR_SLASH);
                while (path_q.size() < n_len)
                    path_q.push_back(($urandom_range(19) == 0) ? CHAR_SLASH : name_char());
            end
            else if (kind < 8)
            begin
                repeat ($urandom_range(8))
                    path_q.push_back(8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    send_beat(OP_IGNORED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else
            begin
                if ($urandom_range(9) != 0)
                    path_q.push_back(CHAR_SLASH);
                n_comp = $urandom_range(7);
                for (int c = 0; c < n_comp; c++)
                begin
                    r = $urandom_range(99);
                    if (r < 10)
                        path_q.push_back(CHAR_DOT);
                    else if (r < 20)
                    begin
                        path_q.push_back(CHAR_DOT);
                        path_q.push_back(CHAR_DOT);
                    end
                    else
                        repeat ($urandom_range(1, 6))
                            path_q.push_back(name_char());
                    if (c < n_comp - 1 || $urandom_range(3) == 0)
                        repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1)
                            path_q.push_back(CHAR_SLASH);
                end
            end
            send_path($urandom_range(3));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_BYTE;
        path_byte     = 8'h00;
        read_index    = 8'h00;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 50;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_strict(1'b0);
        queue_text("x//./y/..");
        send_path(0);
        send_beat(OP_READ, 8'h00, 8'd1);
        send_beat(OP_READ, 8'hFF, 8'd255);
        send_beat(OP_READ, 8'h00, 8'd0);
        send_beat(OP_END, 8'h00, 8'h00);
        queue_text("/..");
        send_path(0);
        path_q = '{8'hFF, 8'h00};
        send_path(1);
        send_beat(OP_IGNORED, 8'hFF, 8'hFF);
        wait_idle();
        write_strict(1'b1);
        queue_text("a");
        send_path(0);
        queue_text("/.");
        send_path(1);
        send_beat(OP_END, 8'hFF, 8'hFF);

        wait_idle();
        write_strict(1'b0);
        run_phase(450);

        wait_idle();
        send_idle_pct = 50;
        recv_idle_pct = 36;
        write_strict(1'b1);
        run_phase(450);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_strict(1'b0);
        stall_asks++;
        run_phase(230);
        path_q.delete();
        repeat (255)
            path_q.push_back(8'h71);
        send_path(2);
        send_beat(OP_READ, 8'h00, 8'd255);

        wait_idle();
        $display("Covered %0d paths in %0d input beats, %0d results checked,",
                 paths_sent, beats_sent, results_seen);
        $display("with strict mode on and off and one %0d-cycle output stall.", LONG_STALL);
        if (mismatches == 0 && pending == 0)
            $display("path_canonicalizer verification clean");
        else
            $display("path_canonicalizer verification failed");
        $finish;
    end

endmodule
